/* src/sla_pkg.sv */
`default_nettype none

package sla_pkg;

   typedef enum logic [1:0] {
      NT_FP32 = 2'd0,
      NT_FP64 = 2'd1,
      NT_INT32 = 2'd2,
      NT_INT64 = 2'd3
   } number_type_type;

   localparam int VECTOR_BITS_DEF = 128;
   localparam int FP32_EBITS = 8;
   localparam int FP32_FBITS = 23;
   localparam int FP64_EBITS = 11;
   localparam int FP64_FBITS = 52;
   localparam int PIPE_STAGES = 3;

endpackage

`default_nettype wire

/* src/sla_stream_if.sv */
`default_nettype none

interface sla_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] a_word0;
   logic [63:0] a_word1;
   logic [63:0] b_word0;
   logic [63:0] b_word1;
   logic [31:0] in_keep;
   logic        in_last;

   modport source (output valid, a_word0, a_word1, b_word0, b_word1, in_keep, in_last,
                   input ready);
   modport sink (input valid, a_word0, a_word1, b_word0, b_word1, in_keep, in_last,
                 output ready);
endinterface

interface sla_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] sum_word0;
   logic [63:0] sum_word1;
   logic [15:0] out_keep;
   logic        out_last;

   modport source (output valid, sum_word0, sum_word1, out_keep, out_last, input ready);
   modport sink (input valid, sum_word0, sum_word1, out_keep, out_last, output ready);
endinterface

`default_nettype wire

/* src/simd_lanewise_adder_unit.sv */
// Channel  Dir  Handshake      Payload
// req_ch   in   valid/ready    a_word0..1, b_word0..1, in_keep, in_last
// rsp_ch   out  valid/ready    sum_word0..1, out_keep, out_last
// csr      in   csr_we         csr_wdata: number type
//
// Three register stages (align, add with zero count, normalize and round);
// one transaction per cycle sustained while the output is not stalled.
// Each stage loads when it is empty or the stage after it moves on, so a
// stalled output holds only the stages behind it that are full.
// Synchronous reset clears the valid bits and the number type.
`default_nettype none

module simd_lanewise_adder_unit
   import sla_pkg::*;
#(
   parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   sla_req_if.sink         req_ch,
   sla_rsp_if.source       rsp_ch,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_wdata
);

   localparam int N32 = VECTOR_BITS / 32;
   localparam int N64 = VECTOR_BITS / 64;
   localparam int KBYTES = VECTOR_BITS / 8;
   localparam logic [15:0] KEEP_MASK = 16'((17'd1 << KBYTES) - 17'd1);

   number_type_type cfg_ff;
   number_type_type t1_ff, t2_ff, t3_ff;
   logic [PIPE_STAGES-1:0] v_ff, stage_en;
   logic [127:0] int1_ff, int2_ff, int3_ff;
   logic [15:0]  k1_ff, k2_ff, k3_ff;
   logic         l1_ff, l2_ff, l3_ff;
   logic [127:0] a_vec, b_vec, isum32, isum64, int_in, f32_res, f64_res, sum_vec;

   assign a_vec = {req_ch.a_word1, req_ch.a_word0};
   assign b_vec = {req_ch.b_word1, req_ch.b_word0};

   always_comb begin
      stage_en[2] = !v_ff[2] || rsp_ch.ready;
      stage_en[1] = !v_ff[1] || stage_en[2];
      stage_en[0] = !v_ff[0] || stage_en[1];
   end

   assign req_ch.ready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= NT_FP32;
         v_ff <= '0;
      end else begin
         if (csr_we) begin
            cfg_ff <= number_type_type'(csr_wdata);
         end
         if (stage_en[0]) v_ff[0] <= req_ch.valid;
         if (stage_en[1]) v_ff[1] <= v_ff[0];
         if (stage_en[2]) v_ff[2] <= v_ff[1];
      end
   end

   genvar j;
   generate
      for (j = 0; j < 4; j++) begin : g_lane32
         if (j < N32) begin : g_on
            assign isum32[32*j +: 32] = a_vec[32*j +: 32] + b_vec[32*j +: 32];
            sla_fp_add #(.EBITS(FP32_EBITS), .FBITS(FP32_FBITS)) u_fp32 (
               .clock   (clock),
               .stage_en(stage_en),
               .a_in    (a_vec[32*j +: 32]),
               .b_in    (b_vec[32*j +: 32]),
               .sum_out (f32_res[32*j +: 32])
            );
         end else begin : g_off
            assign isum32[32*j +: 32] = '0;
            assign f32_res[32*j +: 32] = '0;
         end
      end
      for (j = 0; j < 2; j++) begin : g_lane64
         if (j < N64) begin : g_on
            assign isum64[64*j +: 64] = a_vec[64*j +: 64] + b_vec[64*j +: 64];
            sla_fp_add #(.EBITS(FP64_EBITS), .FBITS(FP64_FBITS)) u_fp64 (
               .clock   (clock),
               .stage_en(stage_en),
               .a_in    (a_vec[64*j +: 64]),
               .b_in    (b_vec[64*j +: 64]),
               .sum_out (f64_res[64*j +: 64])
            );
         end else begin : g_off
            assign isum64[64*j +: 64] = '0;
            assign f64_res[64*j +: 64] = '0;
         end
      end
   endgenerate

   assign int_in = (cfg_ff == NT_INT32) ? isum32 : isum64;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         t1_ff <= cfg_ff;
         int1_ff <= int_in;
         k1_ff <= req_ch.in_keep[15:0] & KEEP_MASK;
         l1_ff <= req_ch.in_last;
      end
      if (stage_en[1]) begin
         t2_ff <= t1_ff;
         int2_ff <= int1_ff;
         k2_ff <= k1_ff;
         l2_ff <= l1_ff;
      end
      if (stage_en[2]) begin
         t3_ff <= t2_ff;
         int3_ff <= int2_ff;
         k3_ff <= k2_ff;
         l3_ff <= l2_ff;
      end
   end

   always_comb begin
      unique case (t3_ff)
         NT_FP32: sum_vec = f32_res;
         NT_FP64: sum_vec = f64_res;
         default: sum_vec = int3_ff;
      endcase
   end

   assign rsp_ch.valid = v_ff[2];
   assign rsp_ch.sum_word0 = sum_vec[63:0];
   assign rsp_ch.sum_word1 = sum_vec[127:64];
   assign rsp_ch.out_keep = k3_ff;
   assign rsp_ch.out_last = l3_ff;

endmodule

`default_nettype wire

/* src/sla_fp_add.sv */
`default_nettype none

module sla_fp_add
   import sla_pkg::*;
#(
   parameter int EBITS = FP32_EBITS,
   parameter int FBITS = FP32_FBITS
) (
   input  wire logic                   clock,
   input  wire logic [PIPE_STAGES-1:0] stage_en,
   input  wire logic [EBITS+FBITS:0]   a_in,
   input  wire logic [EBITS+FBITS:0]   b_in,
   output logic      [EBITS+FBITS:0]   sum_out
);

   localparam int N = EBITS + FBITS + 1;
   localparam int W = FBITS + 4;
   localparam int LZW = $clog2(W + 2);
   localparam int SW = (LZW > EBITS + 1) ? LZW : EBITS + 1;
   localparam logic [EBITS-1:0] EMAX = '1;
   localparam logic [N-1:0] QNAN = {1'b0, EMAX, 1'b1, {(FBITS-1){1'b0}}};

   // stage A: unpack, specials, swap, align
   logic             sa, sb, a_nan, b_nan, a_inf, b_inf, a_big;
   logic [EBITS-1:0] ea, eb, ean, ebn, ex, ey, d;
   logic [FBITS-1:0] fa, fb;
   logic [W-1:0]     ma, mb, mx, my, my_al;
   logic [N-1:0]     spec_val;

   logic             a_sx_ff, a_sa_ff, a_sub_ff, a_spec_ff;
   logic [EBITS-1:0] a_ex_ff;
   logic [W-1:0]     a_mx_ff, a_my_ff;
   logic [N-1:0]     a_spec_val_ff;

   always_comb begin
      sa = a_in[N-1];
      sb = b_in[N-1];
      ea = a_in[N-2:FBITS];
      eb = b_in[N-2:FBITS];
      fa = a_in[FBITS-1:0];
      fb = b_in[FBITS-1:0];
      a_nan = (ea == EMAX) && (fa != '0);
      b_nan = (eb == EMAX) && (fb != '0);
      a_inf = (ea == EMAX) && (fa == '0);
      b_inf = (eb == EMAX) && (fb == '0);
      if (a_nan || b_nan) begin
         spec_val = QNAN;
      end else if (a_inf && b_inf) begin
         spec_val = (sa == sb) ? a_in : QNAN;
      end else if (a_inf) begin
         spec_val = a_in;
      end else begin
         spec_val = b_in;
      end
      ma = {(ea != '0), fa, 3'b000};
      mb = {(eb != '0), fb, 3'b000};
      ean = (ea == '0) ? EBITS'(1) : ea;
      ebn = (eb == '0) ? EBITS'(1) : eb;
      a_big = (ean > ebn) || ((ean == ebn) && (ma >= mb));
      mx = a_big ? ma : mb;
      my = a_big ? mb : ma;
      ex = a_big ? ean : ebn;
      ey = a_big ? ebn : ean;
      d = ex - ey;
      // keep a sticky bit for everything shifted out
      my_al = (my >> d) | W'(|(my & ~({W{1'b1}} << d)));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a_mx_ff <= mx;
         a_my_ff <= my_al;
         a_ex_ff <= ex;
         a_sx_ff <= a_big ? sa : sb;
         a_sa_ff <= sa;
         a_sub_ff <= sa != sb;
         a_spec_ff <= (ea == EMAX) || (eb == EMAX);
         a_spec_val_ff <= spec_val;
      end
   end

   // stage B: add or subtract, leading zero count
   logic [W:0]       m_b;
   logic [LZW-1:0]   lz_b;

   logic [W:0]       b_m_ff;
   logic [LZW-1:0]   b_lz_ff;
   logic [EBITS-1:0] b_ex_ff;
   logic             b_sx_ff, b_sa_ff, b_sub_ff, b_spec_ff;
   logic [N-1:0]     b_spec_val_ff;

   always_comb begin
      m_b = a_sub_ff ? ({1'b0, a_mx_ff} - {1'b0, a_my_ff})
                     : ({1'b0, a_mx_ff} + {1'b0, a_my_ff});
      lz_b = LZW'(W + 1);
      for (int i = 0; i <= W; i++) begin
         if (m_b[i]) begin
            lz_b = LZW'(W - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         b_m_ff <= m_b;
         b_lz_ff <= lz_b;
         b_ex_ff <= a_ex_ff;
         b_sx_ff <= a_sx_ff;
         b_sa_ff <= a_sa_ff;
         b_sub_ff <= a_sub_ff;
         b_spec_ff <= a_spec_ff;
         b_spec_val_ff <= a_spec_val_ff;
      end
   end

   // stage C: normalize, round, pack
   logic [SW-1:0]    sh, sh_max;
   logic [W:0]       mn;
   logic [EBITS:0]   en, en2;
   logic [FBITS:0]   mr;
   logic [FBITS+1:0] mr2;
   logic [2:0]       low;
   logic             inc;
   logic [EBITS-1:0] ee;
   logic [N-1:0]     res;

   always_comb begin
      sh = SW'(b_lz_ff) - SW'(1);
      sh_max = SW'(b_ex_ff) - SW'(1);
      if (b_m_ff[W]) begin
         mn = (b_m_ff >> 1) | (W+1)'(b_m_ff[0]);
         en = {1'b0, b_ex_ff} + (EBITS+1)'(1);
      end else begin
         if (sh > sh_max) begin
            sh = sh_max;
         end
         mn = b_m_ff << sh;
         en = {1'b0, b_ex_ff} - (EBITS+1)'(sh);
      end
      mr = mn[W-1:3];
      low = mn[2:0];
      inc = (low > 3'd4) || ((low == 3'd4) && mr[0]);
      mr2 = {1'b0, mr} + (FBITS+2)'(inc);
      en2 = en;
      if (mr2[FBITS+1]) begin
         mr2 = mr2 >> 1;
         en2 = en + (EBITS+1)'(1);
      end
      ee = mr2[FBITS] ? en2[EBITS-1:0] : '0;
      if (b_spec_ff) begin
         res = b_spec_val_ff;
      end else if (b_m_ff == '0) begin
         res = b_sub_ff ? '0 : {b_sa_ff, {(N-1){1'b0}}};
      end else if (en2 >= {1'b0, EMAX}) begin
         res = {b_sx_ff, EMAX, {FBITS{1'b0}}};
      end else begin
         res = {b_sx_ff, ee, mr2[FBITS-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         sum_out <= res;
      end
   end

endmodule

`default_nettype wire

/* src/sla_checker.sv */
`default_nettype none

module sla_checker
   import sla_pkg::*;
#(
   parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_in_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_out_keep,
   input wire logic        rsp_out_last
);

   localparam int KBYTES = VECTOR_BITS / 8;
   localparam logic [15:0] KEEP_MASK = 16'((17'd1 << KBYTES) - 17'd1);

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   a_reset_empty: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_acc && rsp_ready) ##1 rsp_ready ##1 rsp_ready
      |=> rsp_valid && (rsp_out_last == $past(req_in_last, 3)))
      else $error("transaction not delivered after three cycles");

   a_keep_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_keep & ~KEEP_MASK) == 16'd0))
      else $error("keep bit beyond vector width");

endmodule

bind simd_lanewise_adder_unit sla_checker #(.VECTOR_BITS(VECTOR_BITS)) u_sla_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_in_last (req_ch.in_last),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_out_keep(rsp_ch.out_keep),
   .rsp_out_last(rsp_ch.out_last)
);

`default_nettype wire
